// File: sv/set_assoc_tag_lookup_fifo_core_defines.svh
// assertion macros for the set-associative tag lookup core
// no dependencies; included by files that carry concurrent assertions
`ifndef SET_ASSOC_TAG_LOOKUP_FIFO_CORE_DEFINES_SVH
`define SET_ASSOC_TAG_LOOKUP_FIFO_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define STLF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define STLF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define STLF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define STLF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: sv/stlf_pkg.sv
// shared types for the set-associative tag lookup core
// no dependencies; used by the front, queue, back and top level
package stlf_pkg;

    typedef enum logic [2:0] {
        F_IDLE,
        F_MUL_BLK,
        F_QUO_BLK,
        F_FIX_BLK,
        F_MUL_SET,
        F_QUO_SET,
        F_FIX_SET,
        F_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_CMP
    } back_state_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef struct packed {
        logic        hit;
        logic [12:0] tag_out;
        logic [7:0]  set_index;
        logic [7:0]  byte_offset;
        logic [5:0]  way_used;
    } result_t;

endpackage

// File: sv/stlf_split.sv
// front: accepts an address and splits it into offset, set index and tag
// uses stlf_pkg; two constant divisions by reciprocal on one shared multiplier
module stlf_split #(
    parameter int BLK   = 8,
    parameter int SETS  = 1,
    parameter int TAG_W = 13,
    parameter int SET_W = 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [15:0]                  address,
    output logic                         busy,
    input  stlf_pkg::queue_status_t      q_status,
    output logic                         q_push,
    output logic [TAG_W+SET_W+8-1:0]     q_data
);

    localparam int SB = 16 + $clog2(BLK);
    localparam int SS = 16 + $clog2(SETS);
    localparam logic [63:0] MB_FULL = (64'd1 << SB) / BLK;
    localparam logic [63:0] MS_FULL = (64'd1 << SS) / SETS;
    localparam logic [16:0] MB = MB_FULL[16:0];
    localparam logic [16:0] MS = MS_FULL[16:0];

    stlf_pkg::front_state_t state_reg, state_next;

    logic [15:0]       x_reg;
    logic [32:0]       prod_reg;
    logic [15:0]       q_reg;
    logic [15:0]       blk_reg;
    logic [7:0]        off_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic [SET_W-1:0]  set_reg;

    logic [15:0] mul_a;
    logic [16:0] mul_b;
    logic [32:0] prod_next;
    logic [32:0] sh_b, sh_s;
    logic [15:0] rem_b, rem_s;
    logic        big_b, big_s;
    logic [15:0] fix_b_q, fix_b_r, fix_s_q, fix_s_r;

    assign sh_b = prod_reg >> SB;
    assign sh_s = prod_reg >> SS;

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            stlf_pkg::F_MUL_BLK:
            begin
                mul_a = x_reg;
                mul_b = MB;
            end
            stlf_pkg::F_QUO_BLK:
            begin
                mul_a = sh_b[15:0];
                mul_b = 17'(BLK);
            end
            stlf_pkg::F_MUL_SET:
            begin
                mul_a = blk_reg;
                mul_b = MS;
            end
            stlf_pkg::F_QUO_SET:
            begin
                mul_a = sh_s[15:0];
                mul_b = 17'(SETS);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = 33'(mul_a) * 33'(mul_b);

    // estimated quotient is exact or one low; one compare and subtract fixes it
    assign rem_b   = x_reg - prod_reg[15:0];
    assign big_b   = {1'b0, rem_b} >= 17'(BLK);
    assign fix_b_q = big_b ? q_reg + 16'd1 : q_reg;
    assign fix_b_r = big_b ? rem_b - 16'(BLK) : rem_b;

    assign rem_s   = blk_reg - prod_reg[15:0];
    assign big_s   = {1'b0, rem_s} >= 17'(SETS);
    assign fix_s_q = big_s ? q_reg + 16'd1 : q_reg;
    assign fix_s_r = big_s ? rem_s - 16'(SETS) : rem_s;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            stlf_pkg::F_IDLE:    if (start) state_next = stlf_pkg::F_MUL_BLK;
            stlf_pkg::F_MUL_BLK: state_next = stlf_pkg::F_QUO_BLK;
            stlf_pkg::F_QUO_BLK: state_next = stlf_pkg::F_FIX_BLK;
            stlf_pkg::F_FIX_BLK: state_next = stlf_pkg::F_MUL_SET;
            stlf_pkg::F_MUL_SET: state_next = stlf_pkg::F_QUO_SET;
            stlf_pkg::F_QUO_SET: state_next = stlf_pkg::F_FIX_SET;
            stlf_pkg::F_FIX_SET: state_next = stlf_pkg::F_PUSH;
            stlf_pkg::F_PUSH:    if (!q_status.full) state_next = stlf_pkg::F_IDLE;
            default:             state_next = stlf_pkg::F_IDLE;
        endcase
    end

    always_comb
    begin
        busy   = (state_reg != stlf_pkg::F_IDLE);
        q_push = (state_reg == stlf_pkg::F_PUSH) && !q_status.full;
        q_data = {tag_reg, set_reg, off_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= stlf_pkg::F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            stlf_pkg::F_IDLE:
            begin
                if (start) x_reg <= address;
            end
            stlf_pkg::F_MUL_BLK:
            begin
                prod_reg <= prod_next;
            end
            stlf_pkg::F_QUO_BLK:
            begin
                q_reg    <= sh_b[15:0];
                prod_reg <= prod_next;
            end
            stlf_pkg::F_FIX_BLK:
            begin
                blk_reg <= fix_b_q;
                off_reg <= fix_b_r[7:0];
            end
            stlf_pkg::F_MUL_SET:
            begin
                prod_reg <= prod_next;
            end
            stlf_pkg::F_QUO_SET:
            begin
                q_reg    <= sh_s[15:0];
                prod_reg <= prod_next;
            end
            stlf_pkg::F_FIX_SET:
            begin
                tag_reg <= TAG_W'(fix_s_q);
                set_reg <= SET_W'(fix_s_r);
            end
            default:
            begin
            end
        endcase
    end

endmodule

// File: sv/stlf_queue.sv
// two-entry queue between the address splitter and the tag lookup
// uses stlf_pkg for the status struct
module stlf_queue #(
    parameter int WIDTH = 22
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  logic [WIDTH-1:0]        wr_data,
    input  logic                    pop,
    output logic [WIDTH-1:0]        rd_data,
    output stlf_pkg::queue_status_t status
);

    logic [WIDTH-1:0] mem [2];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       count_reg, count_next;
    logic             do_push, do_pop;

    assign do_push = push && (count_reg != 2'd2);
    assign do_pop  = pop && (count_reg != 2'd0);

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop) count_next = count_reg + 2'd1;
        else if (do_pop && !do_push) count_next = count_reg - 2'd1;
    end

    assign rd_data      = mem[rd_ptr_reg];
    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push) wr_ptr_reg <= ~wr_ptr_reg;
            if (do_pop) rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) mem[wr_ptr_reg] <= wr_data;
    end

endmodule

// File: sv/stlf_lookup.sv
// back: clears the rows after reset, reads the set row, compares all ways, fills on a miss, drives the result
// uses stlf_pkg; row memory holds valid bits, tags and the fifo pointer per set
module stlf_lookup #(
    parameter int WAYS  = 8,
    parameter int SETS  = 1,
    parameter int SET_W = 1,
    parameter int WAY_W = 3,
    parameter int TAG_W = 13
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  stlf_pkg::queue_status_t     q_status,
    input  logic [TAG_W+SET_W+8-1:0]    q_data,
    output logic                        q_pop,
    output logic                        done,
    output stlf_pkg::result_t           result
);

    localparam int ROW_W = WAYS + WAYS * TAG_W + WAY_W;

    stlf_pkg::back_state_t state_reg, state_next;

    logic [ROW_W-1:0] row_mem [SETS];
    logic [ROW_W-1:0] rd_reg;
    logic [ROW_W-1:0] wr_row;
    logic [SET_W-1:0] clr_cnt_reg;
    logic [SET_W-1:0] mem_waddr;
    logic             mem_we;

    logic [TAG_W-1:0] ent_tag_reg;
    logic [SET_W-1:0] ent_set_reg;
    logic [7:0]       ent_off_reg;

    logic             done_reg;
    stlf_pkg::result_t res_reg;

    logic [SET_W-1:0] head_set;
    logic [WAYS-1:0]  hit_vec;
    logic             hit_any, free_any;
    logic [WAY_W-1:0] hit_idx, free_idx, fill_way, way_sel;
    logic [WAY_W-1:0] ptr, ptr_next;
    logic [15:0]      tag16, set16;

    assign head_set = q_data[8 +: SET_W];
    assign ptr      = rd_reg[ROW_W-1 -: WAY_W];

    // lowest matching way and lowest free way
    always_comb
    begin
        hit_any  = 1'b0;
        free_any = 1'b0;
        hit_idx  = '0;
        free_idx = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            hit_vec[w] = rd_reg[w] && (rd_reg[WAYS + w * TAG_W +: TAG_W] == ent_tag_reg);
        end
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (hit_vec[w])
            begin
                hit_any = 1'b1;
                hit_idx = WAY_W'(w);
            end
            if (!rd_reg[w])
            begin
                free_any = 1'b1;
                free_idx = WAY_W'(w);
            end
        end
    end

    always_comb
    begin
        fill_way = free_any ? free_idx : ptr;
        way_sel  = hit_any ? hit_idx : fill_way;
        ptr_next = (ptr == WAY_W'(WAYS - 1)) ? '0 : ptr + 1'b1;
        wr_row   = rd_reg;
        for (int w = 0; w < WAYS; w++)
        begin
            if (WAY_W'(w) == fill_way)
            begin
                wr_row[w] = 1'b1;
                wr_row[WAYS + w * TAG_W +: TAG_W] = ent_tag_reg;
            end
        end
        wr_row[ROW_W-1 -: WAY_W] = ptr_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            stlf_pkg::B_CLEAR:
                if (clr_cnt_reg == SET_W'(SETS - 1)) state_next = stlf_pkg::B_IDLE;
            stlf_pkg::B_IDLE:
                if (!q_status.empty) state_next = stlf_pkg::B_CMP;
            stlf_pkg::B_CMP:
                state_next = stlf_pkg::B_IDLE;
            default:
                state_next = stlf_pkg::B_CLEAR;
        endcase
    end

    always_comb
    begin
        q_pop     = (state_reg == stlf_pkg::B_IDLE) && !q_status.empty;
        mem_we    = 1'b0;
        mem_waddr = ent_set_reg;
        case (state_reg)
            stlf_pkg::B_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
            end
            stlf_pkg::B_CMP:
            begin
                mem_we = !hit_any;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    assign tag16 = 16'(ent_tag_reg);
    assign set16 = 16'(ent_set_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= stlf_pkg::B_CLEAR;
            clr_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == stlf_pkg::B_CLEAR) clr_cnt_reg <= clr_cnt_reg + 1'b1;
            done_reg <= (state_reg == stlf_pkg::B_CMP);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            row_mem[mem_waddr] <= (state_reg == stlf_pkg::B_CLEAR) ? '0 : wr_row;
        end
        rd_reg <= row_mem[head_set];
        if (q_pop)
        begin
            ent_tag_reg <= q_data[8 + SET_W +: TAG_W];
            ent_set_reg <= head_set;
            ent_off_reg <= q_data[7:0];
        end
        if (state_reg == stlf_pkg::B_CMP)
        begin
            res_reg.hit         <= hit_any;
            res_reg.tag_out     <= tag16[12:0];
            res_reg.set_index   <= set16[7:0];
            res_reg.byte_offset <= ent_off_reg;
            res_reg.way_used    <= 6'(way_sel);
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

// File: sv/set_assoc_tag_lookup_fifo_core.sv
// top level of the set-associative tag lookup with fifo replacement
// uses stlf_pkg, stlf_split, stlf_queue, stlf_lookup and the assertion header
//
//  channel   handshake        payload                                     beat taken
//  input     start / busy     address                                     start && !busy
//  result    done (strobe)    hit, tag_out, set_index, byte_offset,       every cycle done is high
//                             way_used
//
// the front takes a new address only while idle: it steps two reciprocal divisions
// through one shared multiplier, then hands the split address to a 2-entry queue.
// the back reads the set row as it pops the queue, compares every way and writes a fill;
// done and the result are both registered from the compare state.
// after reset the back clears the row memory, one set a cycle;
// beats taken meanwhile wait in the queue and busy holds once it is full.
// the receiver cannot stall: done is high for exactly one cycle per result.
`include "set_assoc_tag_lookup_fifo_core_defines.svh"

module set_assoc_tag_lookup_fifo_core #(
    parameter int CACHE_BYTES = 64,
    parameter int BLOCK_BYTES = 8,
    parameter int WAYS        = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] address,
    output logic        done,
    output logic        hit,
    output logic [12:0] tag_out,
    output logic [7:0]  set_index,
    output logic [7:0]  byte_offset,
    output logic [5:0]  way_used
);

    localparam int BLK      = (BLOCK_BYTES < 1) ? 1 : BLOCK_BYTES;
    localparam int WAYS_E   = (WAYS < 1) ? 1 : WAYS;
    localparam int SETS_RAW = CACHE_BYTES / BLK / WAYS_E;
    localparam int SETS     = (SETS_RAW < 1) ? 1 : SETS_RAW;
    localparam int SET_W    = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W    = (WAYS_E > 1) ? $clog2(WAYS_E) : 1;
    localparam int TAG_MAX  = (65535 / BLK) / SETS;
    localparam int TAG_W    = (TAG_MAX > 0) ? $clog2(TAG_MAX + 1) : 1;
    localparam int ENTRY_W  = TAG_W + SET_W + 8;

    stlf_pkg::queue_status_t q_status;
    stlf_pkg::result_t       result;
    logic                    q_push, q_pop;
    logic [ENTRY_W-1:0]      q_wr_data, q_rd_data;

    stlf_split #(
        .BLK   (BLK),
        .SETS  (SETS),
        .TAG_W (TAG_W),
        .SET_W (SET_W)
    ) u_split (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .address  (address),
        .busy     (busy),
        .q_status (q_status),
        .q_push   (q_push),
        .q_data   (q_wr_data)
    );

    stlf_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (q_wr_data),
        .pop     (q_pop),
        .rd_data (q_rd_data),
        .status  (q_status)
    );

    stlf_lookup #(
        .WAYS  (WAYS_E),
        .SETS  (SETS),
        .SET_W (SET_W),
        .WAY_W (WAY_W),
        .TAG_W (TAG_W)
    ) u_lookup (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .q_data   (q_rd_data),
        .q_pop    (q_pop),
        .done     (done),
        .result   (result)
    );

    assign hit         = result.hit;
    assign tag_out     = result.tag_out;
    assign set_index   = result.set_index;
    assign byte_offset = result.byte_offset;
    assign way_used    = result.way_used;

    // an accepted beat always occupies the front for the next cycle
    `STLF_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, start && !busy, busy)
    // the back returns to idle after every compare, so strobes never touch
    `STLF_ASSERT_NEXT(a_done_spaced, clk, rst_n, done, !done)
    // the front only pushes into a queue with room
    `STLF_ASSERT_IMPL(a_push_not_full, clk, rst_n, q_push, !q_status.full)
    // reported way stays inside the set
    `STLF_ASSERT_IMPL(a_way_in_range, clk, rst_n, done, way_used <= 6'(WAYS_E - 1))

endmodule

// File: tb/set_assoc_lookup_checker.sv
// checker for the set-associative tag lookup core: predicts each lookup and compares results
// depends on stlf_pkg for the result layout; watches the start/busy and done channels only
module set_assoc_lookup_checker #(
    parameter int CACHE_BYTES = 64,
    parameter int BLOCK_BYTES = 8,
    parameter int WAYS        = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [15:0] address,
    input  logic        done,
    input  logic        hit,
    input  logic [12:0] tag_out,
    input  logic [7:0]  set_index,
    input  logic [7:0]  byte_offset,
    input  logic [5:0]  way_used,
    output int          mismatches,
    output int          pending
);

    localparam int LINE_B   = (BLOCK_BYTES < 1) ? 1 : BLOCK_BYTES;
    localparam int NUM_WAYS = (WAYS < 1) ? 1 : WAYS;
    localparam int SETS_RAW = CACHE_BYTES / LINE_B / NUM_WAYS;
    localparam int NUM_SETS = (SETS_RAW < 1) ? 1 : SETS_RAW;

    bit                line_ok    [NUM_SETS][NUM_WAYS];
    int unsigned       line_tag   [NUM_SETS][NUM_WAYS];
    int unsigned       victim_ptr [NUM_SETS];
    stlf_pkg::result_t lookups_due[$];
    stlf_pkg::result_t due;
    int                errs = 0;

    // mirror of the tag store: returns what one access reports and applies its fill
    function automatic stlf_pkg::result_t lookup_and_fill(input logic [15:0] a);
        int unsigned       blk;
        int unsigned       set_no;
        int unsigned       tag;
        int unsigned       way;
        bit                found;
        bit                free_way;
        stlf_pkg::result_t r;
        blk      = a / LINE_B;
        set_no   = blk % NUM_SETS;
        tag      = blk / NUM_SETS;
        way      = 0;
        found    = 1'b0;
        free_way = 1'b0;
        for (int w = 0; w < NUM_WAYS; w++)
            if (!found && line_ok[set_no][w] && line_tag[set_no][w] == tag)
            begin
                found = 1'b1;
                way   = w;
            end
        if (!found)
        begin
            for (int w = 0; w < NUM_WAYS; w++)
                if (!free_way && !line_ok[set_no][w])
                begin
                    free_way = 1'b1;
                    way      = w;
                end
            if (!free_way)
                way = victim_ptr[set_no];
            line_tag[set_no][way] = tag;
            line_ok[set_no][way]  = 1'b1;
            // pointer moves on every fill, even into an empty way
            victim_ptr[set_no] = (victim_ptr[set_no] + 1) % NUM_WAYS;
        end
        r.hit         = found;
        r.tag_out     = tag[12:0];
        r.set_index   = set_no[7:0];
        r.byte_offset = 8'(a % LINE_B);
        r.way_used    = way[5:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NUM_SETS; s++)
            begin
                victim_ptr[s] = 0;
                for (int w = 0; w < NUM_WAYS; w++)
                begin
                    line_ok[s][w]  = 1'b0;
                    line_tag[s][w] = 0;
                end
            end
            lookups_due.delete();
            pending <= 0;
        end
        else
        begin
            if (done)
            begin
                if (lookups_due.size() == 0)
                begin
                    $error("result beat with no lookup outstanding");
                    errs++;
                end
                else
                begin
                    due = lookups_due.pop_front();
                    if (hit !== due.hit)
                    begin
                        $error("hit: expected %0d, got %0d", due.hit, hit);
                        errs++;
                    end
                    if (tag_out !== due.tag_out)
                    begin
                        $error("tag_out: expected %0d, got %0d", due.tag_out, tag_out);
                        errs++;
                    end
                    if (set_index !== due.set_index)
                    begin
                        $error("set_index: expected %0d, got %0d", due.set_index, set_index);
                        errs++;
                    end
                    if (byte_offset !== due.byte_offset)
                    begin
                        $error("byte_offset: expected %0d, got %0d",
                               due.byte_offset, byte_offset);
                        errs++;
                    end
                    if (way_used !== due.way_used)
                    begin
                        $error("way_used: expected %0d, got %0d", due.way_used, way_used);
                        errs++;
                    end
                end
            end
            if (start && !busy)
                lookups_due.push_back(lookup_and_fill(address));
            pending <= lookups_due.size();
        end
        mismatches <= errs;
    end

endmodule

// File: tb/testbench.sv
// top of the tag lookup testbench: clock, reset, address stimulus and the verdict
// depends on set_assoc_tag_lookup_fifo_core (with stlf_pkg) and set_assoc_lookup_checker
module testbench;

    localparam int LINE_BYTES = 8;  // matches the block size of the instance below

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [15:0] address;
    logic        done;
    logic        hit;
    logic [12:0] tag_out;
    logic [7:0]  set_index;
    logic [7:0]  byte_offset;
    logic [5:0]  way_used;
    int          mismatches;
    int          pending;

    // fills all eight ways, then forces fifo victims, plus field extremes
    logic [15:0] opening_addrs [19] = '{
        16'h0000, 16'h0000, 16'h0007, 16'hFFFF, 16'hFFF8, 16'h0008, 16'h0010,
        16'h0018, 16'h0020, 16'h0028, 16'h0030, 16'h1234, 16'h0000, 16'hFFFF,
        16'h0015, 16'h8000, 16'h7FFF, 16'hAAAA, 16'h5555
    };

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    set_assoc_tag_lookup_fifo_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .address     (address),
        .done        (done),
        .hit         (hit),
        .tag_out     (tag_out),
        .set_index   (set_index),
        .byte_offset (byte_offset),
        .way_used    (way_used)
    );

    set_assoc_lookup_checker lookup_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .address     (address),
        .done        (done),
        .hit         (hit),
        .tag_out     (tag_out),
        .set_index   (set_index),
        .byte_offset (byte_offset),
        .way_used    (way_used),
        .mismatches  (mismatches),
        .pending     (pending)
    );

    task automatic issue_access(input logic [15:0] a);
        start   <= 1'b1;
        address <= a;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic hold_off(input int n);
        start   <= 1'b0;
        address <= 16'($urandom);
        repeat (n) @(posedge clk);
    endtask

    // stop issuing and let every outstanding lookup come back
    task automatic drain_lookups();
        int waited;
        waited = 0;
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
    endtask

    initial
    begin
        #3_000_000;
        $display("** set_assoc_tag_lookup_fifo_core: FAILED **");
        $finish;
    end

    initial
    begin
        int          hot_tags [16];
        int          hot_count;
        bit          gaps_on;
        logic [15:0] a;
        hot_count = 1;
        gaps_on   = 1'b0;
        rst_n   <= 1'b0;
        start   <= 1'b0;
        address <= 16'h0000;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening_addrs[k])
            issue_access(opening_addrs[k]);
        drain_lookups();

        for (int i = 0; i < 1400; i++)
        begin
            // new working set now and then; its size decides hit rate vs thrashing
            if (i % 150 == 0)
            begin
                hot_count = $urandom_range(4, 14);
                for (int k = 0; k < hot_count; k++)
                    hot_tags[k] = $urandom_range(0, 8191);
                gaps_on = (i < 1200) && ($urandom_range(0, 2) != 0);
            end
            if (i == 700)
                drain_lookups();
            if (gaps_on && $urandom_range(0, 4) == 0)
                hold_off($urandom_range(1, 15));
            if ($urandom_range(0, 9) < 8)
                a = 16'(hot_tags[$urandom_range(0, hot_count - 1)] * LINE_BYTES
                        + $urandom_range(0, LINE_BYTES - 1));
            else
                a = 16'($urandom);
            issue_access(a);
        end

        drain_lookups();
        repeat (30) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("** set_assoc_tag_lookup_fifo_core: PASSED **");
        else
        begin
            if (pending != 0)
                $error("%0d lookups never returned a result", pending);
            $display("** set_assoc_tag_lookup_fifo_core: FAILED **");
        end
        $finish;
    end

endmodule
